// ===== src/stm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding trimmed-mean pH unit.
// No dependencies; every other file of the block imports this package.
package stm_pkg;

  // Field widths fixed by the data format.
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 16;
  localparam int OFFSET_W = 14;
  localparam int MEAN_W   = 20;
  localparam int PH_W     = 16;
  localparam int FRAC_W   = 8;
  localparam int CFG_W    = 16;

  typedef logic [SAMPLE_W-1:0]       sample_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic [MEAN_W-1:0]         mean_t;
  typedef logic signed [PH_W-1:0]    ph_t;
  typedef logic [0:0]                cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_IDX_GAIN   = 1'b0;
  localparam cfg_idx_t CFG_IDX_OFFSET = 1'b1;

  // Register reset values: gain is about 3.5 * 5 / 1024 in Q0.16.
  localparam gain_t   GAIN_RESET   = 16'd1120;
  localparam offset_t OFFSET_RESET = '0;

  // Largest possible trimmed mean, in Q.8.
  localparam mean_t MEAN_MAX = 20'd1048320;

endpackage

// ===== src/stm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on stm_pkg for the payload types.
interface stm_in_if import stm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface stm_out_if import stm_pkg::*; ();
  logic  valid;
  logic  ready;
  mean_t trimmed_mean;
  ph_t   ph_value;

  modport source (output valid, output trimmed_mean, output ph_value, input ready);
  modport sink   (input valid, input trimmed_mean, input ph_value, output ready);
endinterface

// ===== src/stm_ring.sv =====
`timescale 1ns / 1ps
// Sample ring: one write port at the running slot, one registered read port.
// Depends on stm_pkg. Entries never written since reset read as zero.
module stm_ring import stm_pkg::*; #(
  parameter int WINDOW = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  sample_t                   wr_data,
  input  logic [$clog2(WINDOW)-1:0] rd_addr,
  output sample_t                   rd_data
);

  localparam int ADDR_W = $clog2(WINDOW);

  sample_t             mem [WINDOW];
  logic [WINDOW-1:0]   valid_r;
  logic [ADDR_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   slot_nxt;
  sample_t             rd_q_r;
  logic                rd_vld_r;

  // Write slot advances after each write and wraps after the last entry.
  always_comb begin
    if (slot_r == ADDR_W'(WINDOW - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= '0;
    end else if (wr_en) begin
      slot_r          <= slot_nxt;
      valid_r[slot_r] <= 1'b1;
    end
  end

  // Storage array: no reset, the valid bits stand in for the clear.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== src/sliding_trimmed_mean_ph_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sliding trimmed-mean pH unit: sequencer, arithmetic, registers.
// Depends on stm_pkg, stm_if (channels) and stm_ring (sample storage).
//
//  Channel  Dir  Payload                           Transfer when
//  in_ch    in   adc_sample [11:0]                 valid & ready
//  out_ch   out  trimmed_mean [19:0], ph_value     valid & ready
//  cfg_*    in   cfg_index, cfg_wdata [15:0]       cfg_we
//
// The unit takes no new input until the current item has loaded the output
// register; the sweep over the ring through its single read port sets the pace.
// Reset is synchronous; the ring uses per-entry valid bits, so no clearing pass
// is needed and the unit takes items right after reset. A stalled output holds
// in its register while the unit takes and processes the next sample; only the
// final load waits for the output register to free up.
module sliding_trimmed_mean_ph_unit import stm_pkg::*; #(
  parameter int WINDOW = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  stm_in_if.sink         in_ch,
  stm_out_if.source      out_ch,
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int ADDR_W  = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int DIVISOR = WINDOW - 2;
  localparam int DIV_L   = $clog2(DIVISOR);
  localparam int SHIFT   = NUM_W + DIV_L;
  localparam int PROD_W  = 2 * NUM_W + 1;
  localparam int GPROD_W = MEAN_W + GAIN_W;
  localparam int PHS_W   = MEAN_W + 2;
  // Reciprocal of the divisor, exact for every numerator below 2**NUM_W.
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [NUM_W:0]  RECIP_V = RECIP[NUM_W:0];

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_TRIM  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  gain_t              gain_r;
  offset_t            offset_r;
  logic [SUM_W-1:0]   sum_r;
  sample_t            lo_r;
  sample_t            hi_r;
  logic [SUM_W-1:0]   trim_r;
  logic [PROD_W-1:0]  quot_prod_r;
  mean_t              mean_r;
  logic [GPROD_W-1:0] gain_prod_r;
  logic               out_valid_r;
  mean_t              out_mean_r;
  ph_t                out_ph_r;

  logic               in_xfer;
  logic               ring_wr_en;
  sample_t            rd_data;
  logic [NUM_W-1:0]   num;
  mean_t              mean_w;
  logic [MEAN_W-1:0]  scaled;
  logic signed [PHS_W-1:0] ph_sum;
  ph_t                ph_sat;
  logic               out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ring_wr_en  = in_xfer;

  // Sample storage.
  stm_ring #(.WINDOW(WINDOW)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ring_wr_en),
    .wr_data (in_ch.adc_sample),
    .rd_addr (cnt_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_IDX_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: write, sweep the ring, trim, divide, scale, deliver.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (cnt_r == CNT_W'(WINDOW)) begin
          state_nxt = ST_TRIM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TRIM:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Running sum, minimum and maximum; read data belongs to the previous cycle's address.
  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP && cnt_r != '0) begin
      if (cnt_r == CNT_W'(1)) begin
        sum_r <= SUM_W'(rd_data);
        lo_r  <= rd_data;
        hi_r  <= rd_data;
      end else begin
        sum_r <= sum_r + SUM_W'(rd_data);
        if (rd_data < lo_r) begin
          lo_r <= rd_data;
        end
        if (rd_data > hi_r) begin
          hi_r <= rd_data;
        end
      end
    end
  end

  // Datapath stages: trim, divide by reciprocal, scale by gain.
  assign num    = {trim_r, {FRAC_W{1'b0}}};
  assign mean_w = quot_prod_r[SHIFT +: MEAN_W];

  always_ff @(posedge clk) begin
    if (state_r == ST_TRIM) begin
      trim_r <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
    end
    if (state_r == ST_DIV) begin
      quot_prod_r <= PROD_W'(num) * PROD_W'(RECIP_V);
    end
    if (state_r == ST_SCALE) begin
      mean_r      <= mean_w;
      gain_prod_r <= GPROD_W'(mean_w) * GPROD_W'(gain_r);
    end
  end

  // Offset add and saturation to signed Q8.8.
  assign scaled = gain_prod_r[GPROD_W-1 -: MEAN_W];
  assign ph_sum = $signed({2'b00, scaled})
                + $signed({{(PHS_W - OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r});

  always_comb begin
    if (ph_sum > $signed(PHS_W'(32767))) begin
      ph_sat = 16'sh7FFF;
    end else if (ph_sum < -$signed(PHS_W'(32768))) begin
      ph_sat = 16'sh8000;
    end else begin
      ph_sat = ph_sum[PH_W-1:0];
    end
  end

  // Output register: takes the finished result when empty or when its result transfers this cycle.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r <= mean_r;
      out_ph_r   <= ph_sat;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.trimmed_mean = out_mean_r;
  assign out_ch.ph_value     = out_ph_r;

  // An accepted sample always starts a sweep from the first entry.
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SWEEP && cnt_r == '0))
    else $error("sweep did not start after a sample transfer");

  // The sweep counter never runs past the window.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> cnt_r <= CNT_W'(WINDOW))
    else $error("sweep counter beyond window");

  // The ring is never written while a sample is being processed.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !ring_wr_en)
    else $error("ring written during processing");

  // A delivered mean stays within the range of a 12-bit sample in Q.8.
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mean_r <= MEAN_MAX)
    else $error("trimmed mean out of range");

endmodule
